// File: rtl/hrt_pkg.sv
package hrt_pkg;

   // Default sizes for the top-level parameters
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int COORD_BITS_DEF  = 16;

   // Fixed field widths
   localparam int CHAR_BITS = 8;
   localparam int LANE_BITS = 16;
   localparam int SLOT_BITS = 11;

   // Hash and remainder unit
   localparam int                 HASH_BITS    = 64;
   localparam logic [63:0]        HASH_SEED    = 64'd5381;
   localparam int                 HASH_SHIFT   = 5;
   localparam int                 DIV_RADIX    = 4;
   localparam int                 DIV_STEPS    = HASH_BITS / DIV_RADIX;
   localparam int                 DIV_CNT_BITS = $clog2(DIV_STEPS);

   // Slot count register after reset
   localparam logic [SLOT_BITS-1:0] SLOT_COUNT_RESET = 11'd1024;

   // Operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_COMMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic start;
      logic div_step;
      logic read;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic div_done;
   } sts_type;

endpackage

// File: rtl/hrt_ram.sv
module hrt_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or read one word per cycle, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/hrt_ctrl.sv
module hrt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  hrt_pkg::sts_type sts_i,
   output hrt_pkg::cmd_type cmd_o
);

   hrt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hrt_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd_o        = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         hrt_pkg::ST_CLEAR: begin
            cmd_o.clear_step = 1'b1;
            if (sts_i.clear_done) begin
               state_in = hrt_pkg::ST_IDLE;
            end
         end
         hrt_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd_o.accept = req_tvalid;
            cmd_o.start  = req_tvalid && req_tlast;
            if (req_tvalid && req_tlast) begin
               state_in = hrt_pkg::ST_DIV;
            end
         end
         hrt_pkg::ST_DIV: begin
            cmd_o.div_step = 1'b1;
            if (sts_i.div_done) begin
               state_in = hrt_pkg::ST_READ;
            end
         end
         hrt_pkg::ST_READ: begin
            cmd_o.read = 1'b1;
            state_in   = hrt_pkg::ST_COMMIT;
         end
         hrt_pkg::ST_COMMIT: begin
            // Hold until the result register is free
            if (out_free) begin
               cmd_o.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = hrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hrt_pkg::ST_CLEAR;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A commit never overwrites an untaken result
   assert property (@(posedge clock) disable iff (reset)
      cmd_o.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit over a pending result");

   // No item is taken while the store is being cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == hrt_pkg::ST_CLEAR) |-> !cmd_o.accept)
      else $error("item accepted during clearing pass");

endmodule

// File: rtl/hrt_dpath.sv
module hrt_dpath #(
   parameter int TABLE_DEPTH = hrt_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = hrt_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hrt_pkg::cmd_type                     cmd_i,
   output hrt_pkg::sts_type                     sts_o,
   input  logic                                 operation_i,
   input  logic signed [hrt_pkg::CHAR_BITS-1:0] name_char_i,
   input  logic [hrt_pkg::LANE_BITS-1:0]        rect_x_i,
   input  logic [hrt_pkg::LANE_BITS-1:0]        rect_y_i,
   input  logic [hrt_pkg::LANE_BITS-1:0]        rect_w_i,
   input  logic [hrt_pkg::LANE_BITS-1:0]        rect_h_i,
   input  logic                                 csr_valid_i,
   input  logic [hrt_pkg::SLOT_BITS-1:0]        csr_data_i,
   output logic                                 insert_ok_o,
   output logic [hrt_pkg::LANE_BITS-1:0]        found_x_o,
   output logic [hrt_pkg::LANE_BITS-1:0]        found_y_o,
   output logic [hrt_pkg::LANE_BITS-1:0]        found_w_o,
   output logic [hrt_pkg::LANE_BITS-1:0]        found_h_o
);

   localparam int HashW   = hrt_pkg::HASH_BITS;
   localparam int SlotW   = hrt_pkg::SLOT_BITS;
   localparam int LaneW   = hrt_pkg::LANE_BITS;
   localparam int Radix   = hrt_pkg::DIV_RADIX;
   localparam int CntW    = hrt_pkg::DIV_CNT_BITS;
   localparam int AddrW   = $clog2(TABLE_DEPTH);
   localparam int DataW   = 4 * COORD_BITS;
   localparam int EntryW  = DataW + 1;

   // Hash and remainder state
   logic [HashW-1:0]  hash_ff, hash_in, hash_next;
   logic [HashW-1:0]  dividend_ff, dividend_in;
   logic [SlotW-1:0]  rem_ff, rem_in;
   logic [SlotW:0]    trial;
   logic [SlotW-1:0]  div_ff, div_in, div_clamp;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [SlotW-1:0]  slot_count_ff, slot_count_in;

   // Item latched on the last character
   logic              op_ff, op_in;
   logic [DataW-1:0]  rect_ff, rect_in;

   // Clearing pass and memory port
   logic [AddrW-1:0]  clr_addr_ff, clr_addr_in;
   logic [AddrW-1:0]  mem_addr;
   logic              mem_we;
   logic [EntryW-1:0] mem_wdata, mem_rdata;
   logic              slot_empty;

   // Result payload
   logic              ok_ff, ok_in;
   logic [LaneW-1:0]  fx_ff, fy_ff, fw_ff, fh_ff;
   logic [LaneW-1:0]  fx_in, fy_in, fw_in, fh_in;

   // Fold one character into the hash
   assign hash_next = (hash_ff << hrt_pkg::HASH_SHIFT) + hash_ff + HashW'(name_char_i);

   // Clamp the slot count into 1 .. TABLE_DEPTH
   always_comb begin
      if (slot_count_ff == '0) begin
         div_clamp = SlotW'(1);
      end else if (32'(slot_count_ff) > TABLE_DEPTH) begin
         div_clamp = SlotW'(TABLE_DEPTH);
      end else begin
         div_clamp = slot_count_ff;
      end
   end

   // Shift several dividend bits into the remainder per cycle
   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < Radix; i++) begin
         trial = {rem_in, dividend_ff[HashW-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SlotW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = SlotW'(trial);
         end
      end
   end

   // Next values for hash, divider, slot count, clearing address and latched item
   always_comb begin
      hash_in       = hash_ff;
      dividend_in   = dividend_ff;
      div_in        = div_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      rect_in       = rect_ff;
      slot_count_in = csr_valid_i ? csr_data_i : slot_count_ff;
      clr_addr_in   = cmd_i.clear_step ? clr_addr_ff + AddrW'(1) : clr_addr_ff;
      if (cmd_i.accept) begin
         hash_in = cmd_i.start ? hrt_pkg::HASH_SEED : hash_next;
      end
      if (cmd_i.start) begin
         dividend_in = hash_next;
         div_in      = div_clamp;
         cnt_in      = '0;
         op_in       = operation_i;
         rect_in     = {rect_h_i[COORD_BITS-1:0], rect_w_i[COORD_BITS-1:0],
                        rect_y_i[COORD_BITS-1:0], rect_x_i[COORD_BITS-1:0]};
      end
      if (cmd_i.div_step) begin
         dividend_in = dividend_ff << Radix;
         cnt_in      = cnt_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff       <= hrt_pkg::HASH_SEED;
         cnt_ff        <= '0;
         clr_addr_ff   <= '0;
         slot_count_ff <= hrt_pkg::SLOT_COUNT_RESET;
      end else begin
         hash_ff       <= hash_in;
         cnt_ff        <= cnt_in;
         clr_addr_ff   <= clr_addr_in;
         slot_count_ff <= slot_count_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      div_ff      <= div_in;
      op_ff       <= op_in;
      rect_ff     <= rect_in;
      if (cmd_i.start) begin
         rem_ff <= '0;
      end else if (cmd_i.div_step) begin
         rem_ff <= rem_in;
      end
   end

   assign sts_o.div_done   = (cnt_ff == CntW'(hrt_pkg::DIV_STEPS - 1));
   assign sts_o.clear_done = (clr_addr_ff == AddrW'(TABLE_DEPTH - 1));

   // A slot is empty if never written, or if it holds an all-ones full-width word
   assign slot_empty = !mem_rdata[EntryW-1] ||
                       ((COORD_BITS == LaneW) && (&mem_rdata[DataW-1:0]));

   // Share the one memory port between clearing, reading and inserting
   always_comb begin
      mem_addr  = AddrW'(rem_ff);
      mem_we    = 1'b0;
      mem_wdata = {1'b1, rect_ff};
      if (cmd_i.clear_step) begin
         mem_addr  = clr_addr_ff;
         mem_we    = 1'b1;
         mem_wdata = {1'b0, {DataW{1'b1}}};
      end else if (cmd_i.commit) begin
         mem_we = (op_ff == hrt_pkg::OP_INSERT) && slot_empty;
      end
   end

   hrt_ram #(
      .WIDTH (EntryW),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wdata (mem_wdata),
      .re    (cmd_i.read),
      .rdata (mem_rdata)
   );

   // Build the result on commit
   always_comb begin
      ok_in = ok_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (cmd_i.commit) begin
         if (op_ff == hrt_pkg::OP_INSERT) begin
            ok_in = slot_empty;
            fx_in = '0;
            fy_in = '0;
            fw_in = '0;
            fh_in = '0;
         end else begin
            ok_in = 1'b0;
            fx_in = LaneW'(mem_rdata[0*COORD_BITS +: COORD_BITS]);
            fy_in = LaneW'(mem_rdata[1*COORD_BITS +: COORD_BITS]);
            fw_in = LaneW'(mem_rdata[2*COORD_BITS +: COORD_BITS]);
            fh_in = LaneW'(mem_rdata[3*COORD_BITS +: COORD_BITS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      fw_ff <= fw_in;
      fh_ff <= fh_in;
   end

   assign insert_ok_o = ok_ff;
   assign found_x_o   = fx_ff;
   assign found_y_o   = fy_ff;
   assign found_w_o   = fw_ff;
   assign found_h_o   = fh_ff;

   // The slot read always lies inside the slot count in use
   assert property (@(posedge clock) disable iff (reset)
      cmd_i.read |-> (rem_ff < div_ff))
      else $error("slot index beyond slot count");

   // A finished name leaves the hash at its seed
   assert property (@(posedge clock) disable iff (reset)
      cmd_i.start |=> (hash_ff == hrt_pkg::HASH_SEED))
      else $error("hash not reseeded after name");

endmodule

// File: rtl/hashed_rect_table.sv
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   tdata: name_char, rect_x/y/w/h;
//                                               tuser: operation; tlast: last_char
// rsp      out        rsp_tvalid / rsp_tready   tdata: insert_ok, found_x/y/w/h
// csr      in         csr_valid / csr_ready     csr_data: slot_count
//
// A character without the last mark is folded into the hash and req_tready stays
// high. A last character runs through accept, 16 remainder steps of 4 bits each
// on the 64-bit hash, one store read and one commit.
// After reset the store is cleared to the empty marker, one address after another,
// with req_tready low; csr writes are taken throughout.
// A result waits in the output register while the next name streams in; the
// commit of the following result holds until that register is taken.
module hashed_rect_table #(
   parameter int TABLE_DEPTH = hrt_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = hrt_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [71:0]                   req_tdata,  // name_char, rect_x, rect_y, rect_w, rect_h
   input  logic                          req_tuser,  // operation
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [71:0]                   rsp_tdata,  // insert_ok, found_x, found_y, found_w,
                                                     // found_h, zero fill
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hrt_pkg::SLOT_BITS-1:0] csr_data
);

   hrt_pkg::cmd_type                     cmd;
   hrt_pkg::sts_type                     sts;
   logic                                 insert_ok;
   logic [hrt_pkg::LANE_BITS-1:0]        found_x, found_y, found_w, found_h;
   logic signed [hrt_pkg::CHAR_BITS-1:0] name_char;

   assign name_char = req_tdata[7:0];
   assign csr_ready = 1'b1;

   hrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts_i      (sts),
      .cmd_o      (cmd)
   );

   hrt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .sts_o       (sts),
      .operation_i (req_tuser),
      .name_char_i (name_char),
      .rect_x_i    (req_tdata[23:8]),
      .rect_y_i    (req_tdata[39:24]),
      .rect_w_i    (req_tdata[55:40]),
      .rect_h_i    (req_tdata[71:56]),
      .csr_valid_i (csr_valid),
      .csr_data_i  (csr_data),
      .insert_ok_o (insert_ok),
      .found_x_o   (found_x),
      .found_y_o   (found_y),
      .found_w_o   (found_w),
      .found_h_o   (found_h)
   );

   assign rsp_tdata = {7'b0, found_h, found_w, found_y, found_x, insert_ok};

endmodule
